[rtl/core/plp_pkg.sv]
// Package for the priority load shedder: payload structs, register indexes,
// action codes and fixed constants. No dependencies.
package plp_pkg;

   localparam int STACK_DEPTH     = 8;
   localparam int STACK_AW        = 3;
   localparam int COUNT_W         = 4;
   localparam int DEVICE_W        = 3;
   localparam int MASK_W          = 8;
   localparam int PRIO_TABLE_W    = 32;
   localparam int MS_W            = 22;
   localparam int CHECK_PERIOD_MS = 250;
   localparam int MS_PER_S        = 1000;
   localparam int CSR_INDEX_W     = 3;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_OFF  = 2'd1;
   localparam logic [1:0] ACT_ON   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_POWER     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BUFFER_POWER  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CUT_OFF_DELAY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RESTORE_DELAY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ALARM_ENABLED = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LOAD_MASK     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PRIORITY_TAB  = 3'd6;

   localparam logic [14:0]      MAX_POWER_RESET  = 15'd3000;
   localparam logic [14:0]      BUF_POWER_RESET  = 15'd300;
   localparam logic [MS_W-1:0]  CUT_MS_RESET     = 22'd10000;
   localparam logic [MS_W-1:0]  RESTORE_MS_RESET = 22'd60000;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic signed [15:0] total_power_w;
      logic [7:0]         on_mask;
   } req_type;

   typedef struct packed {
      logic       checked;
      logic       overloaded;
      logic       alarm;
      logic [1:0] action;
      logic [2:0] device;
   } rsp_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [31:0]            data;
   } csr_type;

   typedef struct packed {
      logic [32:0] diff;
      logic        neg;
      logic        zero;
   } alu_res_type;

endpackage

[rtl/core/plp_chan_if.sv]
// Valid/ready channel interface carrying one payload per beat.
// The payload type is set where the channel is instantiated.
interface plp_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/plp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the shed stacks.
module plp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/core/plp_alu.sv]
// Shared 33-bit subtract and compare unit of the load shedder sequencer.
// Depends on plp_pkg for the result struct.
module plp_alu (
   input  logic [32:0]          op_a,
   input  logic [32:0]          op_b,
   output plp_pkg::alu_res_type res
);
   import plp_pkg::*;

   logic [32:0] diff;

   // Operands are either zero-extended 32-bit values or sign-extended
   // small values, so the 33-bit difference never overflows.
   assign diff     = op_a - op_b;
   assign res.diff = diff;
   assign res.neg  = diff[32];
   assign res.zero = (diff == 33'd0);

endmodule

[rtl/core/priority_load_shedder_core.sv]
// Top level of the priority load shedder: sequencer, registers and stacks.
// Depends on plp_pkg, plp_chan_if, plp_alu and plp_ram.
//
// One request beat is taken at a time and yields exactly one response beat.
// A request that fails the 250 ms gate goes from the gate subtract and compare
// to the finish state; a restore check adds the overload compare, threshold,
// power compare and restore-time steps, and an overload that runs the shed scan
// adds the overload-time steps, one scan step per device and the push.
// The sequencer then returns to idle before it takes the next request, and the
// finish state waits while the previous response beat has not been taken.
// The steps are sequential because the single 33-bit subtract/compare unit does
// one step per cycle and the priority scan visits one device per cycle.
// A finished response waits in its own register, so the next request
// may be accepted while it is still outstanding. The shed stacks sit in small
// RAMs that are only read below the fill count, so they need no clearing pass
// after reset. Configuration writes are always accepted.
module priority_load_shedder_core #(
   parameter int NUM_DEVICES   = 8,
   parameter int PRIORITY_BITS = 4
) (
   input  logic       clock,
   input  logic       reset,
   plp_chan_if.sink   req_if,
   plp_chan_if.source rsp_if,
   plp_chan_if.sink   csr_if
);
   import plp_pkg::*;

   localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_GATE      = 4'd1;
   localparam logic [3:0] ST_GATE_CMP  = 4'd2;
   localparam logic [3:0] ST_OVL_CMP   = 4'd3;
   localparam logic [3:0] ST_OVL_TIME  = 4'd4;
   localparam logic [3:0] ST_OVL_CMP_T = 4'd5;
   localparam logic [3:0] ST_SCAN      = 4'd6;
   localparam logic [3:0] ST_PUSH      = 4'd7;
   localparam logic [3:0] ST_THR       = 4'd8;
   localparam logic [3:0] ST_RST_CMP   = 4'd9;
   localparam logic [3:0] ST_RST_TIME  = 4'd10;
   localparam logic [3:0] ST_RST_CMP_T = 4'd11;
   localparam logic [3:0] ST_FINISH    = 4'd12;

   // Configuration.
   logic [14:0]             max_ff, buf_ff;
   logic [MS_W-1:0]         cut_ms_ff, restore_ms_ff;
   logic                    alarm_en_ff;
   logic [MASK_W-1:0]       load_mask_ff;
   logic [PRIO_TABLE_W-1:0] prio_table_ff;

   // Sequencer state.
   logic [3:0]               state_ff, state_in;
   req_type                  item_ff, item_in;
   logic [31:0]              tmp_ff, tmp_in;
   logic [31:0]              last_check_ff, last_check_in;
   logic                     flag_ff, flag_in;
   logic [31:0]              start_ff, start_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [PRIORITY_BITS-1:0] best_prio_ff, best_prio_in;
   logic [DEVICE_W-1:0]      best_dev_ff, best_dev_in;
   logic                     found_ff, found_in;
   logic                     checked_ff, checked_in;
   logic                     alarm_ff, alarm_in;
   logic [1:0]               action_ff, action_in;
   logic [DEVICE_W-1:0]      device_ff, device_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Shared unit and stack RAM ports.
   logic [32:0]          alu_a, alu_b;
   alu_res_type          alu;
   logic                 alu_gt;
   logic                 dev_we, time_we;
   logic [STACK_AW-1:0]  top_addr, time_waddr;
   logic [DEVICE_W-1:0]  dev_rd;
   logic [31:0]          time_rd, time_wdata;

   logic                     req_beat, rsp_free, push_ok;
   logic [PRIO_TABLE_W-1:0]  prio_word;
   logic [PRIORITY_BITS-1:0] prio;
   logic                     cand;

   assign req_beat     = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff        <= MAX_POWER_RESET;
         buf_ff        <= BUF_POWER_RESET;
         cut_ms_ff     <= CUT_MS_RESET;
         restore_ms_ff <= RESTORE_MS_RESET;
         alarm_en_ff   <= 1'b1;
         load_mask_ff  <= '0;
         prio_table_ff <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.data.index)
            REG_MAX_POWER:     max_ff        <= csr_if.data.data[14:0];
            REG_BUFFER_POWER:  buf_ff        <= csr_if.data.data[14:0];
            REG_CUT_OFF_DELAY: cut_ms_ff     <= MS_W'(csr_if.data.data[11:0]) * MS_W'(MS_PER_S);
            REG_RESTORE_DELAY: restore_ms_ff <= MS_W'(csr_if.data.data[11:0]) * MS_W'(MS_PER_S);
            REG_ALARM_ENABLED: alarm_en_ff   <= csr_if.data.data[0];
            REG_LOAD_MASK:     load_mask_ff  <= csr_if.data.data[MASK_W-1:0];
            REG_PRIORITY_TAB:  prio_table_ff <= csr_if.data.data;
            default: begin
            end
         endcase
      end
   end

   plp_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu)
   );

   assign alu_gt = !alu.neg && !alu.zero;

   assign top_addr = STACK_AW'(count_ff - 1'b1);

   plp_ram #(.WIDTH(DEVICE_W), .DEPTH(STACK_DEPTH)) u_dev_stack (
      .clock   (clock),
      .wr_en   (dev_we),
      .wr_addr (count_ff[STACK_AW-1:0]),
      .wr_data (best_dev_ff),
      .rd_addr (top_addr),
      .rd_data (dev_rd)
   );

   plp_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_time_stack (
      .clock   (clock),
      .wr_en   (time_we),
      .wr_addr (time_waddr),
      .wr_data (time_wdata),
      .rd_addr (top_addr),
      .rd_data (time_rd)
   );

   // Priority of the device under the scan; bits beyond the table read as zero.
   always_comb begin
      prio_word = '0;
      if (int'(idx_ff) * PRIORITY_BITS < PRIO_TABLE_W) begin
         prio_word = prio_table_ff >> (int'(idx_ff) * PRIORITY_BITS);
      end
      prio = prio_word[PRIORITY_BITS-1:0];
   end

   assign cand = (int'(idx_ff) < MASK_W) && load_mask_ff[DEVICE_W'(idx_ff)]
                 && item_ff.on_mask[DEVICE_W'(idx_ff)] && alu_gt;

   assign push_ok = found_ff && (count_ff < COUNT_W'(STACK_DEPTH));

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      tmp_in        = tmp_ff;
      last_check_in = last_check_ff;
      flag_in       = flag_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      best_prio_in  = best_prio_ff;
      best_dev_in   = best_dev_ff;
      found_in      = found_ff;
      checked_in    = checked_ff;
      alarm_in      = alarm_ff;
      action_in     = action_ff;
      device_in     = device_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      alu_a         = '0;
      alu_b         = '0;
      dev_we        = 1'b0;
      time_we       = 1'b0;
      time_waddr    = count_ff[STACK_AW-1:0];
      time_wdata    = item_ff.now_ms;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               item_in    = req_if.data;
               checked_in = 1'b0;
               alarm_in   = 1'b0;
               action_in  = ACT_NONE;
               device_in  = '0;
               state_in   = ST_GATE;
            end
         end
         ST_GATE: begin
            alu_a    = {1'b0, item_ff.now_ms};
            alu_b    = {1'b0, last_check_ff};
            tmp_in   = alu.diff[31:0];
            state_in = ST_GATE_CMP;
         end
         ST_GATE_CMP: begin
            alu_a = {1'b0, tmp_ff};
            alu_b = 33'(CHECK_PERIOD_MS);
            if (!alu.neg) begin
               checked_in    = 1'b1;
               last_check_in = item_ff.now_ms;
               state_in      = ST_OVL_CMP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_OVL_CMP: begin
            alu_a = {{17{item_ff.total_power_w[15]}}, item_ff.total_power_w};
            alu_b = {18'd0, max_ff};
            if (alu_gt) begin
               if (!flag_ff) begin
                  start_in = item_ff.now_ms;
               end
               flag_in  = 1'b1;
               alarm_in = alarm_en_ff;
               state_in = ST_OVL_TIME;
            end else begin
               flag_in  = 1'b0;
               state_in = ST_THR;
            end
         end
         ST_OVL_TIME: begin
            alu_a    = {1'b0, item_ff.now_ms};
            alu_b    = {1'b0, start_ff};
            tmp_in   = alu.diff[31:0];
            state_in = ST_OVL_CMP_T;
         end
         ST_OVL_CMP_T: begin
            alu_a = {1'b0, tmp_ff};
            alu_b = 33'(cut_ms_ff);
            if (alu_gt) begin
               idx_in       = '0;
               best_prio_in = '0;
               found_in     = 1'b0;
               state_in     = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            // A strict greater-than against a running best that starts at
            // zero keeps the lowest index on ties and skips zero priorities.
            alu_a = 33'(prio);
            alu_b = 33'(best_prio_ff);
            if (cand) begin
               best_prio_in = prio;
               best_dev_in  = DEVICE_W'(idx_ff);
               found_in     = 1'b1;
            end
            if (idx_ff == IDX_W'(NUM_DEVICES - 1)) begin
               state_in = ST_PUSH;
            end else begin
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end
         ST_PUSH: begin
            if (push_ok) begin
               dev_we    = 1'b1;
               time_we   = 1'b1;
               count_in  = COUNT_W'(count_ff + 1'b1);
               start_in  = item_ff.now_ms;
               action_in = ACT_OFF;
               device_in = best_dev_ff;
            end
            state_in = ST_FINISH;
         end
         ST_THR: begin
            alu_a    = {18'd0, max_ff};
            alu_b    = {18'd0, buf_ff};
            tmp_in   = alu.diff[31:0];
            state_in = ST_RST_CMP;
         end
         ST_RST_CMP: begin
            alu_a = {{17{item_ff.total_power_w[15]}}, item_ff.total_power_w};
            alu_b = {tmp_ff[31], tmp_ff};
            if (alu.neg && (count_ff != '0)) begin
               state_in = ST_RST_TIME;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RST_TIME: begin
            alu_a    = {1'b0, item_ff.now_ms};
            alu_b    = {1'b0, time_rd};
            tmp_in   = alu.diff[31:0];
            state_in = ST_RST_CMP_T;
         end
         ST_RST_CMP_T: begin
            alu_a = {1'b0, tmp_ff};
            alu_b = 33'(restore_ms_ff);
            if (alu_gt) begin
               action_in = ACT_ON;
               device_in = dev_rd;
               count_in  = COUNT_W'(count_ff - 1'b1);
               // The entry that becomes the new top restarts its restore delay.
               if (count_ff > COUNT_W'(1)) begin
                  time_we    = 1'b1;
                  time_waddr = STACK_AW'(count_ff - COUNT_W'(2));
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.checked    = checked_ff;
               rsp_data_in.overloaded = flag_ff;
               rsp_data_in.alarm      = alarm_ff;
               rsp_data_in.action     = action_ff;
               rsp_data_in.device     = device_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_check_ff <= '0;
         flag_ff       <= 1'b0;
         start_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_check_ff <= last_check_in;
         flag_ff       <= flag_in;
         start_ff      <= start_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      tmp_ff       <= tmp_in;
      idx_ff       <= idx_in;
      best_prio_ff <= best_prio_in;
      best_dev_ff  <= best_dev_in;
      found_ff     <= found_in;
      checked_ff   <= checked_in;
      alarm_ff     <= alarm_in;
      action_ff    <= action_in;
      device_ff    <= device_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STACK_DEPTH))
      else $error("shed count beyond stack depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && push_ok) |=> count_ff == COUNT_W'($past(count_ff) + 1'b1))
      else $error("push did not advance the shed count");

   a_action_checked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.action != ACT_NONE) |-> rsp_data_ff.checked)
      else $error("action reported without a check");

   a_alarm_overload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.alarm) |-> rsp_data_ff.overloaded)
      else $error("alarm without overload");
`endif

endmodule
